FILE: sv/texture_edge_padding_unit_defines.svh
// ---------------------------------------------------------------------------
// Texture edge padding: assertion macros
// Shared concurrent-assertion shorthands for the padding block.
// ---------------------------------------------------------------------------
`ifndef TEXTURE_EDGE_PADDING_UNIT_DEFINES_SVH
`define TEXTURE_EDGE_PADDING_UNIT_DEFINES_SVH

// cond must hold whenever trig holds
`define TEP_ASSERT_IMP(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// cond must never be seen
`define TEP_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> 1'b0) \
    else $error(msg);

`endif

FILE: sv/tep_pkg.sv
// ---------------------------------------------------------------------------
// Texture edge padding package
// Sizes, register indexes and the job record passed front to back.
// ---------------------------------------------------------------------------
package tep_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_RADIUS  = 16;
  localparam int MAX_HEIGHT  = 4096;
  localparam int STORE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH + MAX_RADIUS + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ENTRY_W     = 33;
  localparam int OPAQUE_BIT  = 32;

  localparam int W_W        = 11;
  localparam int H_W        = 13;
  localparam int R_W        = 5;
  localparam int CH_W       = 3;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int LAG_W = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int N_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int D_W   = $clog2(MAX_RADIUS + 1) + 1;
  localparam int D2_W  = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);

  localparam int AUTO_SHIFT = 8;   // divide by 256
  localparam int AUTO_MAX   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [ADDR_W-1:0] ctr;
    logic [W_W-1:0]    w;
    logic [H_W-1:0]    h;
    logic [R_W-1:0]    r;
    logic [CH_W-1:0]   ch;
    logic              frame_end;
  } tep_job_t;

endpackage

FILE: sv/tep_pix_if.sv
// ---------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one input pixel.
// ---------------------------------------------------------------------------
interface tep_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;
  logic [7:0] chan3;
  logic [7:0] alpha;

  modport source (output valid, chan0, chan1, chan2, chan3, alpha, input ready);
  modport sink   (input valid, chan0, chan1, chan2, chan3, alpha, output ready);
endinterface

FILE: sv/tep_res_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result pixel.
// ---------------------------------------------------------------------------
interface tep_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out0;
  logic [7:0] out1;
  logic [7:0] out2;
  logic [7:0] out3;
  logic       was_padded;
  logic       frame_end;

  modport source (output valid, out0, out1, out2, out3, was_padded, frame_end,
                  input ready);
  modport sink   (input valid, out0, out1, out2, out3, was_padded, frame_end,
                  output ready);
endinterface

FILE: sv/tep_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/tep_queue.sv
// ---------------------------------------------------------------------------
// Job queue
// Two-entry FIFO of search jobs between front and back.
// ---------------------------------------------------------------------------
module tep_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tep_pkg::tep_job_t push_job,
  output logic              full,
  input  logic              pop,
  output tep_pkg::tep_job_t pop_job,
  output logic              empty
);
  import tep_pkg::*;

  tep_job_t   slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_job;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end
endmodule

FILE: sv/tep_front.sv
// ---------------------------------------------------------------------------
// Padding front end
// Latches frame settings, writes pixels to the row store, issues jobs.
// ---------------------------------------------------------------------------
module tep_front (
  input  logic                           clk,
  input  logic                           rst,
  tep_pix_if.sink                        pixel,
  input  logic [tep_pkg::W_W-1:0]        image_width,
  input  logic [tep_pkg::H_W-1:0]        image_height,
  input  logic [tep_pkg::R_W-1:0]        pad_radius,
  input  logic [tep_pkg::CH_W-1:0]       channel_count,
  input  logic                           q_full,
  input  logic                           drained,
  output logic                           push,
  output tep_pkg::tep_job_t              job,
  output logic                           st_we,
  output logic [tep_pkg::ADDR_W-1:0]     st_addr,
  output logic [tep_pkg::ENTRY_W-1:0]    st_data
);
  import tep_pkg::*;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    ptr_inc = (p == ADDR_W'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic              active;
  logic [W_W-1:0]    fw;
  logic [H_W-1:0]    fh;
  logic [R_W-1:0]    fr;
  logic [CH_W-1:0]   fch;
  logic [LAG_W-1:0]  flag;
  logic [N_W-1:0]    n;
  logic [H_W-1:0]    in_row;
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] out_ptr;

  logic [W_W-1:0]   w_eff;
  logic [H_W-1:0]   h_eff;
  logic [CH_W-1:0]  ch_eff;
  logic [H_W:0]     wh_sum;
  logic [H_W:0]     auto_r;
  logic [R_W-1:0]   r_auto;
  logic [R_W-1:0]   r_eff;
  logic [LAG_W:0]   lag_full;
  logic [W_W-1:0]   cur_w;
  logic [H_W-1:0]   cur_h;
  logic [R_W-1:0]   cur_r;
  logic [CH_W-1:0]  cur_ch;
  logic [LAG_W-1:0] cur_lag;
  logic             accept;
  logic             due;
  logic             fe;

  // frame settings as they would be latched now
  always_comb begin
    if (image_width == '0) w_eff = W_W'(1);
    else if (image_width > W_W'(MAX_WIDTH)) w_eff = W_W'(MAX_WIDTH);
    else w_eff = image_width;
    h_eff = (image_height == '0) ? H_W'(1) : image_height;
    if (channel_count == '0) ch_eff = CH_W'(1);
    else if (channel_count > CH_W'(4)) ch_eff = CH_W'(4);
    else ch_eff = channel_count;
    wh_sum = (H_W+1)'(w_eff) + (H_W+1)'(h_eff);
    auto_r = wh_sum >> AUTO_SHIFT;
    if (auto_r == '0) r_auto = R_W'(1);
    else if (auto_r > (H_W+1)'(AUTO_MAX)) r_auto = R_W'(AUTO_MAX);
    else r_auto = R_W'(auto_r);
    r_eff = (pad_radius == '0) ? r_auto : pad_radius;
    if (r_eff > R_W'(MAX_RADIUS)) r_eff = R_W'(MAX_RADIUS);
    lag_full = (LAG_W+1)'(r_eff) * (LAG_W+1)'(w_eff) + (LAG_W+1)'(r_eff);
  end

  assign cur_w   = active ? fw  : w_eff;
  assign cur_h   = active ? fh  : h_eff;
  assign cur_r   = active ? fr  : r_eff;
  assign cur_ch  = active ? fch : ch_eff;
  assign cur_lag = active ? flag : LAG_W'(lag_full);

  // a new frame waits until the back end has finished the previous one
  assign pixel.ready = !q_full && (active || drained);
  assign accept = pixel.valid && pixel.ready;
  assign due    = (n >= N_W'(cur_lag));
  assign fe     = (out_row == ROW_W'(cur_h - 1'b1)) && (out_col == COL_W'(cur_w - 1'b1));

  assign st_we   = accept && (in_row < cur_h);
  assign st_addr = wr_ptr;
  assign st_data = {pixel.alpha != 8'd0, pixel.chan3, pixel.chan2, pixel.chan1, pixel.chan0};

  assign push          = accept && due;
  assign job.row       = out_row;
  assign job.col       = out_col;
  assign job.ctr       = out_ptr;
  assign job.w         = cur_w;
  assign job.h         = cur_h;
  assign job.r         = cur_r;
  assign job.ch        = cur_ch;
  assign job.frame_end = fe;

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      fw      <= '0;
      fh      <= '0;
      fr      <= '0;
      fch     <= '0;
      flag    <= '0;
      n       <= '0;
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
      wr_ptr  <= '0;
      out_ptr <= '0;
    end else if (accept) begin
      wr_ptr <= ptr_inc(wr_ptr);
      if (!active) begin
        fw      <= w_eff;
        fh      <= h_eff;
        fr      <= r_eff;
        fch     <= ch_eff;
        flag    <= LAG_W'(lag_full);
        out_ptr <= wr_ptr;
      end
      if (due && fe) begin
        active  <= 1'b0;
        n       <= '0;
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
      end else begin
        active <= 1'b1;
        n      <= n + 1'b1;
        if (W_W'(in_col) + W_W'(1) >= cur_w) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
        if (due) begin
          out_ptr <= ptr_inc(out_ptr);
          if (W_W'(out_col) + W_W'(1) >= cur_w) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end
endmodule

FILE: sv/tep_back.sv
// ---------------------------------------------------------------------------
// Padding back end
// Scans the kernel disc one position a cycle and builds the result.
// ---------------------------------------------------------------------------
module tep_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  output logic                        pop,
  output logic                        idle,
  input  tep_pkg::tep_job_t           job_in,
  output logic [tep_pkg::ADDR_W-1:0]  rd_addr,
  input  logic [tep_pkg::ENTRY_W-1:0] rd_data,
  tep_res_if.source                   result
);
  import tep_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SELF  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam int OFF_W = ADDR_W + 1;
  localparam int RAW_W = ADDR_W + 2;
  localparam int KI_W  = ROW_W + 2;
  localparam int KJ_W  = COL_W + 2;

  logic [2:0]              state;
  tep_job_t                job;
  logic signed [D_W-1:0]   di;
  logic signed [D_W-1:0]   dj;
  logic signed [OFF_W-1:0] row_off;
  logic                    pend_valid;
  logic                    pend_self;
  logic [D2_W-1:0]         pend_d2;
  logic [ENTRY_W-1:0]      self_q;
  logic                    found;
  logic [D2_W-1:0]         best;
  logic [31:0]             found_color;
  logic                    res_valid;
  logic [31:0]             res_color;
  logic                    res_padded;
  logic                    res_fend;

  logic signed [D_W-1:0]     r_s;
  logic [OFF_W-1:0]          rw;
  logic [D2_W-1:0]           r_sq;
  logic signed [2*D_W-1:0]   di_sq;
  logic signed [2*D_W-1:0]   dj_sq;
  logic [D2_W-1:0]           d2;
  logic signed [KI_W-1:0]    ki;
  logic signed [KJ_W-1:0]    kj;
  logic                      pos_ok;
  logic signed [OFF_W-1:0]   off;
  logic signed [RAW_W-1:0]   raw;
  logic signed [RAW_W-1:0]   wrapped;
  logic                      take;
  logic                      repl;
  logic [31:0]               mix;

  assign r_s   = $signed(D_W'(job.r));
  assign rw    = OFF_W'(job.r) * OFF_W'(job.w);
  assign r_sq  = D2_W'(job.r) * D2_W'(job.r);
  assign di_sq = di * di;
  assign dj_sq = dj * dj;
  assign d2    = D2_W'(di_sq) + D2_W'(dj_sq);
  assign ki    = $signed({2'b00, job.row}) + KI_W'(di);
  assign kj    = $signed({2'b00, job.col}) + KJ_W'(dj);
  assign pos_ok = (ki >= 0) && (ki < $signed({1'b0, job.h})) &&
                  (kj >= 0) && (kj < $signed({1'b0, job.w})) &&
                  (d2 <= r_sq) && !((di == 0) && (dj == 0));

  // ring address of the candidate, wrapped once either way
  always_comb begin
    off = row_off + OFF_W'(dj);
    raw = $signed({2'b00, job.ctr}) + RAW_W'(off);
    if (raw < 0) wrapped = raw + RAW_W'(STORE_DEPTH);
    else if (raw >= RAW_W'(STORE_DEPTH)) wrapped = raw - RAW_W'(STORE_DEPTH);
    else wrapped = raw;
    rd_addr = (state == S_SCAN) ? ADDR_W'(wrapped) : job.ctr;
  end

  assign pop  = (state == S_IDLE) && !q_empty;
  assign idle = (state == S_IDLE);
  assign take = (state == S_FIN) && (!res_valid || result.ready);
  assign repl = found && !self_q[OPAQUE_BIT];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mix[8*i +: 8] = (repl && (CH_W'(i) < job.ch)) ? found_color[8*i +: 8]
                                                     : self_q[8*i +: 8];
    end
  end

  assign result.valid      = res_valid;
  assign result.out0       = res_color[7:0];
  assign result.out1       = res_color[15:8];
  assign result.out2       = res_color[23:16];
  assign result.out3       = res_color[31:24];
  assign result.was_padded = res_padded;
  assign result.frame_end  = res_fend;

  always_ff @(posedge clk) begin
    if (pop) job <= job_in;
    if (take) begin
      res_color  <= mix;
      res_padded <= repl;
      res_fend   <= job.frame_end;
    end
    // consume read data issued last cycle
    if (pend_valid) begin
      if (pend_self) begin
        self_q <= rd_data;
      end else if (rd_data[OPAQUE_BIT] && (!found || pend_d2 < best)) begin
        found       <= 1'b1;
        best        <= pend_d2;
        found_color <= rd_data[31:0];
      end
    end
    if (state == S_SELF) begin
      found   <= 1'b0;
      di      <= -r_s;
      dj      <= -r_s;
      row_off <= -$signed(rw);
    end else if (state == S_SCAN) begin
      pend_d2 <= d2;
      if (dj == r_s) begin
        dj      <= -r_s;
        di      <= di + 1'b1;
        row_off <= row_off + $signed(OFF_W'(job.w));
      end else begin
        dj <= dj + 1'b1;
      end
    end

    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      pend_self  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (take) res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          pend_valid <= 1'b0;
          pend_self  <= 1'b0;
          if (pop) state <= S_SELF;
        end
        S_SELF: begin
          pend_valid <= 1'b1;
          pend_self  <= 1'b1;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          pend_valid <= pos_ok;
          pend_self  <= 1'b0;
          if ((dj == r_s) && (di == r_s)) state <= S_DRAIN;
        end
        S_DRAIN: begin
          pend_valid <= 1'b0;
          pend_self  <= 1'b0;
          state      <= S_FIN;
        end
        S_FIN: begin
          pend_valid <= 1'b0;
          pend_self  <= 1'b0;
          if (take) state <= S_IDLE;
        end
        default: begin
          pend_valid <= 1'b0;
          pend_self  <= 1'b0;
          state      <= S_IDLE;
        end
      endcase
    end
  end
endmodule

FILE: sv/texture_edge_padding_unit.sv
// ---------------------------------------------------------------------------
// Texture edge padding unit
// Streams raster pixels and fills transparent ones from the nearest opaque
// neighbor inside a disc of radius R.
// ---------------------------------------------------------------------------
//
//  Channel   Dir  Handshake        Carries
//  pixel     in   valid / ready    chan0..chan3, alpha
//  result    out  valid / ready    out0..out3, was_padded, frame_end
//  cfg_*     in   cfg_wr_en only   cfg_index, cfg_data
//
// The back end searches one job at a time, one kernel position per cycle
//   through the single read port of the row store.
// The front end takes a pixel per cycle while the two-entry job queue has room;
//   a frame's first item waits until the back end has drained the last frame.
// Results lag pixels by R*W+R items; send that many filler items after a frame.
// Reset clears all control state; the row store is not cleared (never read
//   before written in a frame), so there is no clearing pass.
// A stalled result register does not block the front until the queue fills.
//
`include "texture_edge_padding_unit_defines.svh"

module texture_edge_padding_unit (
  input  logic                             clk,
  input  logic                             rst,
  tep_pix_if.sink                          pixel,
  tep_res_if.source                        result,
  input  logic                             cfg_wr_en,
  input  logic [tep_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tep_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tep_pkg::*;

  // config registers, sampled by the front on a frame's first item
  logic [W_W-1:0]  image_width;
  logic [H_W-1:0]  image_height;
  logic [R_W-1:0]  pad_radius;
  logic [CH_W-1:0] channel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= W_W'(256);
      image_height  <= H_W'(256);
      pad_radius    <= '0;
      channel_count <= CH_W'(4);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WIDTH:    image_width   <= cfg_data[W_W-1:0];
        REG_HEIGHT:   image_height  <= cfg_data[H_W-1:0];
        REG_RADIUS:   pad_radius    <= cfg_data[R_W-1:0];
        REG_CHANNELS: channel_count <= cfg_data[CH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front -> queue -> back
  logic               push;
  logic               q_full;
  logic               q_empty;
  logic               pop;
  logic               back_idle;
  logic               drained;
  tep_job_t           push_job;
  tep_job_t           pop_job;

  // row store ring, written by the front, read by the back
  logic               st_we;
  logic [ADDR_W-1:0]  st_addr;
  logic [ENTRY_W-1:0] st_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  // nothing queued and nothing being searched
  assign drained = q_empty && back_idle;

  tep_front u_front (
    .clk           (clk),
    .rst           (rst),
    .pixel         (pixel),
    .image_width   (image_width),
    .image_height  (image_height),
    .pad_radius    (pad_radius),
    .channel_count (channel_count),
    .q_full        (q_full),
    .drained       (drained),
    .push          (push),
    .job           (push_job),
    .st_we         (st_we),
    .st_addr       (st_addr),
    .st_data       (st_data)
  );

  tep_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  tep_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_addr),
    .wdata (st_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  tep_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .pop     (pop),
    .idle    (back_idle),
    .job_in  (pop_job),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .result  (result)
  );

  // queue must never overflow or underflow; ring pointer stays in range
  `TEP_ASSERT_NEVER(a_no_overflow, clk, rst, push && q_full, "job queue overflow")
  `TEP_ASSERT_NEVER(a_no_underflow, clk, rst, pop && q_empty, "job queue underflow")
  `TEP_ASSERT_IMP(a_store_addr, clk, rst, st_we, st_addr < ADDR_W'(STORE_DEPTH), "bad store addr")

endmodule
